>>> rtl/core/tts_pkg.sv
`default_nettype none

package tts_pkg;

    localparam int MAX_THREADS_DEF = 16;

    localparam int ID_W     = 16;
    localparam int TK_W     = 8;
    localparam int DRAW_W   = 32;
    localparam int MODE_W   = 2;
    localparam int POLICY_W = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_O_W = 4;
    localparam int COUNT_O_W = 5;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = MODE_W;
    localparam int RES_W     = STATUS_W + SLOT_O_W + COUNT_O_W;
    localparam int M_TDATA_W = 16;

    typedef logic [SLOT_O_W-1:0]  t_slot_o;
    typedef logic [COUNT_O_W-1:0] t_count_o;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TK_W-1:0] tickets;
    } t_entry;

    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SCHED  = 2'd3;

    localparam logic [POLICY_W-1:0] POL_ROUND_ROBIN = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LOTTERY     = 2'd1;
    localparam logic [POLICY_W-1:0] POL_SOFT_RT     = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/tts_table.sv
`default_nettype none

module tts_table #(
    parameter int DEPTH = tts_pkg::MAX_THREADS_DEF,
    parameter int AW    = $clog2(tts_pkg::MAX_THREADS_DEF)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire tts_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output tts_pkg::t_entry      o_rdata
);

    tts_pkg::t_entry r_mem [DEPTH];
    tts_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tts_remainder.sv
`default_nettype none

// restoring remainder, one dividend bit per cycle
module tts_remainder #(
    parameter int VW = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tts_pkg::DRAW_W-1:0] i_dividend,
    input  wire logic [VW-1:0]              i_divisor,
    output logic                            o_done,
    output logic [VW-1:0]                   o_rem
);

    localparam int DW  = tts_pkg::DRAW_W;
    localparam int NW  = $clog2(DW + 1);

    typedef logic [NW-1:0] t_cnt;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [VW-1:0] r_dvs, n_dvs;

    logic [VW:0]   trial;
    logic [VW:0]   diff;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = t_cnt'(DW);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[VW-1:0];
            end else begin
                n_rem = trial[VW-1:0];
            end
            if (r_cnt == t_cnt'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/core/thread_table_scheduler.sv
// Thread table scheduler: a compact table of thread entries (id, tickets,
// exited mark) driven by one command per input transfer.
// Input stream: tuser[1:0] is the command (create, exit by id, finish the
// selected entry, schedule); tdata carries id, tickets and a random draw.
// Output stream: one result transfer per command with status, selected
// slot and entry count after the command.
// Policy register: written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, the block itself has no check for this.
// Ids and tickets sit in a single-port-read table memory with registered
// read data; every scan reads one entry per cycle. Create and finish need
// no scan; exit by id scans for the id; round robin reduces current+1 below
// the entry count and walks; lottery does two table scans plus a bit-serial remainder.
// One command is in work at a time; a new one is taken while the previous
// result still waits in the output register. If the receiver stalls, the
// finished result waits for the output register and no command is taken.
// Synchronous reset empties the table, clears all exited marks, selects
// slot 0 and sets the round robin policy; ids and tickets are not cleared.
`default_nettype none

module thread_table_scheduler #(
    parameter int MAX_THREADS = tts_pkg::MAX_THREADS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [tts_pkg::POLICY_W-1:0]   i_cfg_wr_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] thread_id, [23:16] tickets, [55:24] random_value
    input  wire logic [tts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] mode
    input  wire logic [tts_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [5:2] selected_slot, [10:6] thread_count, rest zero
    output logic [tts_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int SW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int TW = $clog2(MAX_THREADS * ((1 << tts_pkg::TK_W) - 1) + 1);
    localparam int PAD_W = tts_pkg::M_TDATA_W - tts_pkg::RES_W;

    typedef logic [CW-1:0] t_cnt;
    typedef logic [TW-1:0] t_sum;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_EXIT_SCAN = 9'b000000010,
        ST_FIN_READ  = 9'b000000100,
        ST_RR_REDUCE = 9'b000001000,
        ST_RR_WALK   = 9'b000010000,
        ST_LOT_SUM   = 9'b000100000,
        ST_LOT_DIV   = 9'b001000000,
        ST_LOT_WALK  = 9'b010000000,
        ST_RESP      = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [tts_pkg::POLICY_W-1:0] r_policy;
    logic [CW-1:0]                r_count, n_count;
    logic [SW-1:0]                r_cur, n_cur;
    logic [MAX_THREADS-1:0]       r_exited, n_exited;
    logic [tts_pkg::STATUS_W-1:0] r_status, n_status;
    logic [tts_pkg::ID_W-1:0]     r_tid, n_tid;
    logic [tts_pkg::DRAW_W-1:0]   r_draw, n_draw;
    logic [CW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_pipe_vld, n_pipe_vld;
    logic [SW-1:0]                r_pipe_idx;
    logic [TW-1:0]                r_acc, n_acc;
    logic [TW-1:0]                r_rem, n_rem;
    logic [CW-1:0]                r_pos, n_pos;
    logic [CW-1:0]                r_k, n_k;
    logic                         r_m_valid, n_m_valid;
    logic [tts_pkg::M_TDATA_W-1:0] r_m_data, n_m_data;

    logic                         s_xfer;
    logic [tts_pkg::MODE_W-1:0]   in_mode;
    logic [tts_pkg::ID_W-1:0]     in_tid;
    logic [tts_pkg::TK_W-1:0]     in_tk;
    logic [tts_pkg::DRAW_W-1:0]   in_draw;

    logic                         tbl_we, tbl_re;
    logic [SW-1:0]                tbl_waddr, tbl_raddr;
    tts_pkg::t_entry              tbl_wdata, rd_data;

    logic                         div_start, div_done;
    logic [TW-1:0]                div_rem;

    logic                         scan_issue;
    logic [CW-1:0]                last;
    logic [SW-1:0]                last_slot;
    logic [TW-1:0]                cum;

    assign s_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_mode = s_axis_tuser[tts_pkg::MODE_W-1:0];
    assign in_tid  = s_axis_tdata[15:0];
    assign in_tk   = s_axis_tdata[23:16];
    assign in_draw = s_axis_tdata[55:24];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign scan_issue = (r_rd_idx < r_count);
    assign last       = r_count - 1'b1;
    assign last_slot  = last[SW-1:0];
    assign cum        = r_acc + t_sum'(rd_data.tickets);

    tts_table #(
        .DEPTH (MAX_THREADS),
        .AW    (SW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (rd_data)
    );

    tts_remainder #(
        .VW (TW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_draw),
        .i_divisor  (r_acc),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cur      = r_cur;
        n_exited   = r_exited;
        n_status   = r_status;
        n_tid      = r_tid;
        n_draw     = r_draw;
        n_rd_idx   = r_rd_idx;
        n_pipe_vld = 1'b0;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_k        = r_k;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        tbl_we     = 1'b0;
        tbl_waddr  = r_cur;
        tbl_wdata  = rd_data;
        tbl_re     = 1'b0;
        tbl_raddr  = r_rd_idx[SW-1:0];
        div_start  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_tid    = in_tid;
                    n_draw   = in_draw;
                    n_rd_idx = '0;
                    n_acc    = '0;
                    n_status = tts_pkg::STAT_OK;
                    case (in_mode)
                        tts_pkg::MODE_CREATE: begin
                            if (r_count == t_cnt'(MAX_THREADS)) begin
                                n_status = tts_pkg::STAT_FULL;
                            end else begin
                                tbl_we    = 1'b1;
                                tbl_waddr = r_count[SW-1:0];
                                tbl_wdata = '{id: in_tid, tickets: in_tk};
                                n_exited[r_count[SW-1:0]] = 1'b0;
                                n_count   = r_count + 1'b1;
                            end
                            n_state = ST_RESP;
                        end
                        tts_pkg::MODE_EXIT: begin
                            n_state = ST_EXIT_SCAN;
                        end
                        tts_pkg::MODE_FINISH: begin
                            if (r_count == '0 || t_cnt'(r_cur) >= r_count) begin
                                n_status = tts_pkg::STAT_NONE;
                                n_state  = ST_RESP;
                            end else begin
                                tbl_re    = 1'b1;
                                tbl_raddr = last_slot;
                                n_state   = ST_FIN_READ;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = tts_pkg::STAT_NONE;
                                n_state  = ST_RESP;
                            end else if (r_policy == tts_pkg::POL_LOTTERY) begin
                                n_state = ST_LOT_SUM;
                            end else begin
                                n_pos   = t_cnt'(r_cur) + 1'b1;
                                n_k     = '0;
                                n_state = ST_RR_REDUCE;
                            end
                        end
                    endcase
                end
            end

            ST_EXIT_SCAN: begin
                tbl_re     = scan_issue;
                n_pipe_vld = scan_issue;
                if (scan_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_pipe_vld && rd_data.id == r_tid) begin
                    n_exited[r_pipe_idx] = 1'b1;
                    n_status = tts_pkg::STAT_OK;
                    n_state  = ST_RESP;
                end else if (!r_pipe_vld && !scan_issue) begin
                    n_status = tts_pkg::STAT_NOT_FOUND;
                    n_state  = ST_RESP;
                end
            end

            ST_FIN_READ: begin
                if (r_cur != last_slot) begin
                    tbl_we           = 1'b1;
                    tbl_waddr        = r_cur;
                    tbl_wdata        = rd_data;
                    n_exited[r_cur]  = r_exited[last_slot];
                end
                n_exited[last_slot] = 1'b0;
                n_count  = last;
                n_status = tts_pkg::STAT_OK;
                n_state  = ST_RESP;
            end

            ST_RR_REDUCE: begin
                if (r_pos >= r_count) begin
                    n_pos = r_pos - r_count;
                end else begin
                    n_state = ST_RR_WALK;
                end
            end

            ST_RR_WALK: begin
                if (!r_exited[r_pos[SW-1:0]]) begin
                    n_cur    = r_pos[SW-1:0];
                    n_status = tts_pkg::STAT_OK;
                    n_state  = ST_RESP;
                end else if (r_k == last) begin
                    n_status = tts_pkg::STAT_NONE;
                    n_state  = ST_RESP;
                end else begin
                    n_k = r_k + 1'b1;
                    if (r_pos + 1'b1 == r_count) begin
                        n_pos = '0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            ST_LOT_SUM: begin
                tbl_re     = scan_issue;
                n_pipe_vld = scan_issue;
                if (scan_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_pipe_vld && !r_exited[r_pipe_idx]) begin
                    n_acc = cum;
                end else if (!r_pipe_vld && !scan_issue) begin
                    if (r_acc == '0) begin
                        n_status = tts_pkg::STAT_NONE;
                        n_state  = ST_RESP;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_LOT_DIV;
                    end
                end
            end

            ST_LOT_DIV: begin
                if (div_done) begin
                    n_rem    = div_rem;
                    n_acc    = '0;
                    n_rd_idx = '0;
                    n_state  = ST_LOT_WALK;
                end
            end

            ST_LOT_WALK: begin
                tbl_re     = scan_issue;
                n_pipe_vld = scan_issue;
                if (scan_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_pipe_vld && !r_exited[r_pipe_idx]) begin
                    n_acc = cum;
                    if (r_rem < cum) begin
                        n_cur    = r_pipe_idx;
                        n_status = tts_pkg::STAT_OK;
                        n_state  = ST_RESP;
                    end
                end else if (!r_pipe_vld && !scan_issue) begin
                    n_status = tts_pkg::STAT_NONE;
                    n_state  = ST_RESP;
                end
            end

            ST_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{PAD_W{1'b0}},
                                 tts_pkg::t_count_o'(r_count),
                                 tts_pkg::t_slot_o'(r_cur),
                                 r_status};
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_policy   <= tts_pkg::POL_ROUND_ROBIN;
            r_count    <= '0;
            r_cur      <= '0;
            r_exited   <= '0;
            r_pipe_vld <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
            r_count    <= n_count;
            r_cur      <= n_cur;
            r_exited   <= n_exited;
            r_pipe_vld <= n_pipe_vld;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_tid      <= n_tid;
        r_draw     <= n_draw;
        r_rd_idx   <= n_rd_idx;
        r_pipe_idx <= tbl_raddr;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_m_data   <= n_m_data;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_THREADS))
        else $error("entry count beyond table depth");

    a_exited_live_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exited >> r_count) == '0)
        else $error("exited mark set on a free slot");

    a_create_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && in_mode == tts_pkg::MODE_CREATE && r_count != t_cnt'(MAX_THREADS))
        |=> r_count == t_cnt'($past(r_count) + 1'b1))
        else $error("create did not add an entry");

    a_finish_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN_READ) |=> r_count == t_cnt'($past(r_count) - 1'b1))
        else $error("finish did not remove an entry");

endmodule

`default_nettype wire
